FILE: sv/irps_pkg.sv
// irps_pkg: shared types, constants and codes of the IR proximity scan sequencer.
// No dependencies; used by the top level, irps_ctrl and irps_dp.
package irps_pkg;

  localparam int LEVELS       = 5;
  localparam int SLOTS        = 4;
  localparam int SAMPLE_WIDTH = 10;

  localparam int LVL_W   = 3;
  localparam int SLOT_W  = 2;
  localparam int BR_W    = 10;
  localparam int CH_W    = 4;
  localparam int MAP_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 16;
  localparam int ST_DEPTH = LEVELS * SLOTS;
  localparam int ST_AW    = $clog2(ST_DEPTH);

  // brightness registers sit at indexes 0 .. NUM_BRIGHT-1, channel map follows
  localparam int NUM_BRIGHT = 5;
  localparam logic [CFG_IDX_W-1:0] REG_CHMAP = CFG_IDX_W'(NUM_BRIGHT);

  localparam logic [BR_W-1:0] BRIGHT_RST [NUM_BRIGHT] =
    '{10'd380, 10'd390, 10'd400, 10'd410, 10'd420};
  localparam logic [MAP_W-1:0] CHMAP_RST = 16'h8115;

  localparam logic CMD_START  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic KIND_REQ   = 1'b0;
  localparam logic KIND_FINAL = 1'b1;

  localparam logic [1:0] COL_BRIGHT = 2'd0;
  localparam logic [1:0] COL_LEFT   = 2'd1;
  localparam logic [1:0] COL_MID    = 2'd2;
  localparam logic [1:0] COL_RIGHT  = 2'd3;

  typedef struct packed {
    logic                    cmd;
    logic [SAMPLE_WIDTH-1:0] adc_sample;
  } irps_in_t;

  typedef struct packed {
    logic              kind;
    logic [BR_W-1:0]   brightness;
    logic              led_right;
    logic [CH_W-1:0]   adc_channel;
    logic [LVL_W-1:0]  level_index;
    logic [1:0]        value_index;
    logic [SAMPLE_WIDTH-1:0] value;
    logic              last;
  } irps_out_t;

  // controller -> datapath
  typedef struct packed {
    logic              accept;
    logic              ld_req;
    logic              ld_fin;
    logic [1:0]        col;
    logic [SLOT_W-1:0] rd_slot;
    logic              cap_acc;
    logic              rl_clr;
    logic              rl_inc;
  } irps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;
    logic out_free;
    logic rl_last;
  } irps_stat_t;

endpackage

FILE: sv/ir_proximity_scan_sequencer.sv
// IR proximity scan sequencer, top level: irps_ctrl plus irps_dp.
// Conversion request: once an input request is taken, S_REQ loads it into the output register when that is free.
// End of scan: 20 final values, read level by level in states S_BR to S_C3 (one store read port).
// Throughput: one input request at a time; the input stalls until its results are loaded.
// Reset (rst_n, sync): counters cleared, registers to defaults, store left unwritten.
module ir_proximity_scan_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  irps_pkg::irps_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output irps_pkg::irps_out_t            out_data,
  input  logic                           cfg_we,
  input  logic [irps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irps_pkg::CFG_W-1:0]     cfg_data
);
  import irps_pkg::*;

  irps_cmd_t  cmd;
  irps_stat_t stat;

  irps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  irps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat)
  );

  // a taken request always blocks the next one
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken twice in a row");

  a_req_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_REQ) |-> out_data.last)
    else $error("conversion request without last");

  a_fin_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_FINAL) |-> (out_data.level_index < LVL_W'(LEVELS)))
    else $error("final value row out of range");

  // results are only loaded while no input is being taken
  a_no_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |-> !(cmd.ld_req || cmd.ld_fin))
    else $error("result load overlaps input accept");

endmodule

FILE: sv/irps_ram.sv
// irps_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module irps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/irps_ctrl.sv
// irps_ctrl: sequencing state machine (request accept, request issue, readout).
// Depends on irps_pkg; drives the datapath through irps_cmd_t.
module irps_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  irps_pkg::irps_stat_t stat,
  output irps_pkg::irps_cmd_t  cmd
);
  import irps_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_REQ  = 4'd1;
  localparam logic [3:0] S_BR   = 4'd2;
  localparam logic [3:0] S_C1   = 4'd3;
  localparam logic [3:0] S_R1   = 4'd4;
  localparam logic [3:0] S_R2   = 4'd5;
  localparam logic [3:0] S_C2   = 4'd6;
  localparam logic [3:0] S_R3   = 4'd7;
  localparam logic [3:0] S_C3   = 4'd8;

  logic [3:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (stat.scan_end) begin
            cmd.rl_clr = 1'b1;
            state_nxt  = S_BR;
          end else begin
            state_nxt  = S_REQ;
          end
        end
      end
      S_REQ: begin
        if (stat.out_free) begin
          cmd.ld_req = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_BR: begin
        cmd.rd_slot = SLOT_W'(0);
        cmd.col     = COL_BRIGHT;
        if (stat.out_free) begin
          cmd.ld_fin = 1'b1;
          state_nxt  = S_C1;
        end
      end
      S_C1: begin
        cmd.rd_slot = SLOT_W'(0);
        cmd.col     = COL_LEFT;
        if (stat.out_free) begin
          cmd.ld_fin = 1'b1;
          state_nxt  = S_R1;
        end
      end
      S_R1: begin
        cmd.rd_slot = SLOT_W'(1);
        state_nxt   = S_R2;
      end
      S_R2: begin
        // read data now holds slot 1
        cmd.rd_slot = SLOT_W'(2);
        cmd.cap_acc = 1'b1;
        state_nxt   = S_C2;
      end
      S_C2: begin
        cmd.rd_slot = SLOT_W'(2);
        cmd.col     = COL_MID;
        if (stat.out_free) begin
          cmd.ld_fin = 1'b1;
          state_nxt  = S_R3;
        end
      end
      S_R3: begin
        cmd.rd_slot = SLOT_W'(3);
        state_nxt   = S_C3;
      end
      S_C3: begin
        cmd.rd_slot = SLOT_W'(3);
        cmd.col     = COL_RIGHT;
        if (stat.out_free) begin
          cmd.ld_fin = 1'b1;
          if (stat.rl_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.rl_inc = 1'b1;
            state_nxt  = S_BR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/irps_dp.sv
// irps_dp: counters, configuration registers, sample store and result register.
// Depends on irps_pkg and irps_ram; steered by irps_ctrl.
module irps_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  irps_pkg::irps_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output irps_pkg::irps_out_t                 out_data,
  input  logic                                cfg_we,
  input  logic [irps_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [irps_pkg::CFG_W-1:0]          cfg_data,
  input  irps_pkg::irps_cmd_t                 cmd,
  output irps_pkg::irps_stat_t                stat
);
  import irps_pkg::*;

  logic [BR_W-1:0]   bright_r [NUM_BRIGHT];
  logic [MAP_W-1:0]  chmap_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [LVL_W-1:0]  rl_r, rl_nxt;
  logic [SAMPLE_WIDTH-1:0] acc_r;
  logic              out_valid_r, out_valid_nxt;
  irps_out_t         out_r, out_nxt;

  logic [SAMPLE_WIDTH-1:0] rdata;
  logic [SAMPLE_WIDTH:0]   mid_sum;
  logic [LVL_W-1:0]  br_lvl;
  logic [BR_W-1:0]   br_val;
  logic              st_we;
  logic              scan_end;

  assign st_we = cmd.accept && (in_data.cmd == CMD_SAMPLE);

  irps_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (ST_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (ST_AW'({lvl_r, slot_r})),
    .wdata (in_data.adc_sample),
    .raddr (ST_AW'({rl_r, cmd.rd_slot})),
    .rdata (rdata)
  );

  assign scan_end = (in_data.cmd == CMD_SAMPLE) && (slot_r == SLOT_W'(SLOTS - 1))
                    && (lvl_r == LVL_W'(LEVELS - 1));

  assign stat.scan_end = scan_end;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign stat.rl_last  = (rl_r == LVL_W'(LEVELS - 1));

  // levels without a brightness register read as zero
  assign br_lvl = cmd.ld_fin ? rl_r : lvl_r;
  always_comb begin
    br_val = '0;
    if (br_lvl < LVL_W'(NUM_BRIGHT)) begin
      br_val = bright_r[br_lvl];
    end
  end

  assign mid_sum = {1'b0, acc_r} + {1'b0, rdata};

  always_comb begin
    slot_nxt = slot_r;
    lvl_nxt  = lvl_r;
    if (cmd.accept) begin
      if (in_data.cmd == CMD_START || scan_end) begin
        slot_nxt = '0;
        lvl_nxt  = '0;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
        if (slot_r == SLOT_W'(SLOTS - 1)) begin
          lvl_nxt = lvl_r + LVL_W'(1);
        end
      end
    end
  end

  always_comb begin
    rl_nxt = rl_r;
    if (cmd.rl_clr) begin
      rl_nxt = '0;
    end else if (cmd.rl_inc) begin
      rl_nxt = rl_r + LVL_W'(1);
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.ld_req) begin
      out_nxt             = '0;
      out_nxt.kind        = KIND_REQ;
      out_nxt.brightness  = br_val;
      out_nxt.led_right   = slot_r[SLOT_W-1];
      out_nxt.adc_channel = chmap_r[slot_r*CH_W +: CH_W];
      out_nxt.last        = 1'b1;
      out_valid_nxt       = 1'b1;
    end else if (cmd.ld_fin) begin
      out_nxt             = '0;
      out_nxt.kind        = KIND_FINAL;
      out_nxt.level_index = rl_r;
      out_nxt.value_index = cmd.col;
      out_nxt.last        = (cmd.col == COL_RIGHT) && stat.rl_last;
      case (cmd.col)
        COL_BRIGHT: out_nxt.value = br_val;
        COL_MID:    out_nxt.value = mid_sum[SAMPLE_WIDTH:1];
        default:    out_nxt.value = rdata;
      endcase
      out_valid_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      lvl_r       <= '0;
      rl_r        <= '0;
      out_valid_r <= 1'b0;
      chmap_r     <= CHMAP_RST;
      for (int i = 0; i < NUM_BRIGHT; i++) begin
        bright_r[i] <= BRIGHT_RST[i];
      end
    end else begin
      slot_r      <= slot_nxt;
      lvl_r       <= lvl_nxt;
      rl_r        <= rl_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index < CFG_IDX_W'(NUM_BRIGHT)) begin
          bright_r[cfg_index] <= cfg_data[BR_W-1:0];
        end else if (cfg_index == REG_CHMAP) begin
          chmap_r <= cfg_data[MAP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.cap_acc) begin
      acc_r <= rdata;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
